// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the Golomb encoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, held off while arst_n is low
`define GE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// A condition that must never be seen on a clock edge
`define GE_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: hw/rtl/golenc_pkg.sv
// Types and fixed widths shared by the Golomb encoder modules
package golenc_pkg;

	localparam int VALUE_W   = 16;  // value port and divider width
	localparam int NB_W      = 5;   // holds ceil(log2 m), 0..16
	localparam int CODE_W    = 32;  // code_bits port
	localparam int CNT_W     = 6;   // bit_count port
	localparam int DIV_STEPS = 16;  // one quotient bit per cycle

	typedef struct packed {
		logic               start;
		logic [VALUE_W-1:0] dividend;
		logic [VALUE_W-1:0] divisor;  // never zero
	} div_req_t;

	typedef struct packed {
		logic               done;     // one-cycle pulse, fields then hold
		logic [VALUE_W-1:0] quot;
		logic [VALUE_W-1:0] rem;
		logic [NB_W-1:0]    nbits;    // ceil(log2 divisor)
	} div_res_t;

endpackage

// File: hw/rtl/golenc_div.sv
// Bit-serial restoring divider, also finds ceil(log2 divisor)
`include "assert_macros.svh"

module golenc_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  golenc_pkg::div_req_t  req,
	output golenc_pkg::div_res_t  res
);

	logic [golenc_pkg::NB_W-1:0]    cnt_q;
	logic                           done_q;
	logic [golenc_pkg::VALUE_W-1:0] rem_q;
	logic [golenc_pkg::VALUE_W-1:0] quo_q;
	logic [golenc_pkg::VALUE_W-1:0] dvs_q;
	logic [golenc_pkg::VALUE_W-1:0] mm1_q;
	logic [golenc_pkg::NB_W-1:0]    nbits_q;

	logic [golenc_pkg::VALUE_W:0]   trial;
	logic [golenc_pkg::VALUE_W:0]   diff;
	logic                           ge;
	logic                           busy;

	assign busy  = (cnt_q != '0);
	assign trial = {rem_q, quo_q[golenc_pkg::VALUE_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == golenc_pkg::NB_W'(1));
			if (req.start) begin
				cnt_q <= golenc_pkg::NB_W'(golenc_pkg::DIV_STEPS);
			end else if (busy) begin
				cnt_q <= cnt_q - golenc_pkg::NB_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q   <= req.dividend;
			rem_q   <= '0;
			dvs_q   <= req.divisor;
			mm1_q   <= req.divisor - golenc_pkg::VALUE_W'(1);
			nbits_q <= '0;
		end else if (busy) begin
			// dividend bits leave at the top, quotient bits enter at the bottom
			quo_q <= {quo_q[golenc_pkg::VALUE_W-2:0], ge};
			rem_q <= ge ? diff[golenc_pkg::VALUE_W-1:0] : trial[golenc_pkg::VALUE_W-1:0];
			if (mm1_q != '0) begin
				nbits_q <= nbits_q + golenc_pkg::NB_W'(1);
				mm1_q   <= mm1_q >> 1;
			end
		end
	end

	assign res.done  = done_q;
	assign res.quot  = quo_q;
	assign res.rem   = rem_q;
	assign res.nbits = nbits_q;

	`GE_NEVER(a_start_idle, req.start && busy, "divider restarted mid-division")
	`GE_ASSERT(a_done_rem, done_q |-> (rem_q < dvs_q), "remainder not below divisor")

endmodule

// File: hw/rtl/golomb_encoder_top.sv
// Golomb encoder top level: divider, remainder coding and chunk packer
//
//  channel  dir  handshake               payload
//  in       in   in_valid / in_stall     value
//  out      out  out_valid / out_stall   code_bits, bit_count, last, overflow
//  cfg      in   cfg_wr_en               cfg_wr_data (divisor m)
//
// A word is split into quotient and remainder by the 16 steps of the
// bit-serial divider, planned in S_PREP and S_PLAN, then coded one code bit
// per cycle (q + 1 + remainder bits); overflow words go to S_OVF instead.
// A full chunk waits in the output register; the packer only stops when
// that register is still held by out_stall. Reset sets divisor to 1.
`include "assert_macros.svh"

module golomb_encoder_top #(
	parameter int VALUE_BITS   = 16,
	parameter int MAX_QUOTIENT = 1024,
	parameter int CHUNK_BITS   = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [golenc_pkg::VALUE_W-1:0] cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [golenc_pkg::VALUE_W-1:0] value,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [golenc_pkg::CODE_W-1:0]  code_bits,
	output logic [golenc_pkg::CNT_W-1:0]   bit_count,
	output logic                           last,
	output logic                           overflow
);

	localparam int VB        = (VALUE_BITS > golenc_pkg::VALUE_W) ? golenc_pkg::VALUE_W
	                                                                : VALUE_BITS;
	localparam logic [golenc_pkg::VALUE_W-1:0] VMASK =
		golenc_pkg::VALUE_W'((33'd1 << VB) - 33'd1);
	localparam int CW        = (CHUNK_BITS > golenc_pkg::CODE_W) ? golenc_pkg::CODE_W
	                                                               : CHUNK_BITS;
	localparam int TOTAL_MAX = 64 * CW;
	localparam int QW        = $clog2(MAX_QUOTIENT + 1);
	localparam int TW        = golenc_pkg::VALUE_W + 2;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_PREP, S_PLAN, S_UNARY, S_STOP, S_REM, S_OVF
	} state_t;

	state_t                          state_q;
	logic [golenc_pkg::VALUE_W-1:0]  divisor_q;
	logic [golenc_pkg::VALUE_W-1:0]  u_q;
	logic                            pow2_q;
	logic [QW-1:0]                   ones_q;
	logic [golenc_pkg::NB_W-1:0]     rb_q;
	logic [golenc_pkg::VALUE_W-1:0]  rval_q;
	logic [golenc_pkg::CODE_W-1:0]   cur_q;
	logic [golenc_pkg::CNT_W-1:0]    fill_q;
	logic                            out_valid_q;
	logic [golenc_pkg::CODE_W-1:0]   out_code_q;
	logic [golenc_pkg::CNT_W-1:0]    out_cnt_q;
	logic                            out_last_q;
	logic                            out_ovf_q;

	golenc_pkg::div_req_t            div_req;
	golenc_pkg::div_res_t            div_res;

	logic [golenc_pkg::VALUE_W-1:0]  m_eff;
	logic                            accept;
	logic                            out_busy;

	// remainder plan
	logic [golenc_pkg::NB_W-1:0]     plan_rbits;
	logic [golenc_pkg::VALUE_W-1:0]  plan_rval;
	logic [TW-1:0]                   plan_total;
	logic                            plan_ovf;

	// packer step
	logic                            bit_val;
	logic                            bit_last;
	logic [golenc_pkg::CODE_W-1:0]   cur_next;
	logic [golenc_pkg::CNT_W-1:0]    fill_next;
	logic                            flush;

	assign m_eff    = (divisor_q == '0) ? golenc_pkg::VALUE_W'(1) : divisor_q;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;

	assign div_req.start    = accept;
	assign div_req.dividend = value & VMASK;
	assign div_req.divisor  = m_eff;

	golenc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	always_comb begin
		plan_rbits = '0;
		plan_rval  = '0;
		if (m_eff != golenc_pkg::VALUE_W'(1)) begin
			if (pow2_q) begin
				plan_rbits = div_res.nbits;
				plan_rval  = div_res.rem;
			end else if (div_res.rem < u_q) begin
				plan_rbits = div_res.nbits - golenc_pkg::NB_W'(1);
				plan_rval  = div_res.rem;
			end else begin
				plan_rbits = div_res.nbits;
				plan_rval  = div_res.rem + u_q;
			end
		end
		plan_total = TW'(div_res.quot) + TW'(1) + TW'(plan_rbits);
		plan_ovf   = (TW'(div_res.quot) > TW'(MAX_QUOTIENT)) ||
		             (plan_total > TW'(TOTAL_MAX));
	end

	always_comb begin
		bit_val  = 1'b0;
		bit_last = 1'b0;
		case (state_q)
			S_UNARY: begin
				bit_val = 1'b1;
			end
			S_STOP: begin
				bit_last = (rb_q == '0);
			end
			S_REM: begin
				bit_val  = rval_q[4'(rb_q - golenc_pkg::NB_W'(1))];
				bit_last = (rb_q == golenc_pkg::NB_W'(1));
			end
			default: begin
				bit_val = 1'b0;
			end
		endcase
		cur_next = cur_q;
		cur_next[5'(golenc_pkg::CNT_W'(golenc_pkg::CODE_W - 1) - fill_q)] = bit_val;
		fill_next = fill_q + golenc_pkg::CNT_W'(1);
		flush     = bit_last || (fill_next == golenc_pkg::CNT_W'(CW));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			divisor_q   <= golenc_pkg::VALUE_W'(1);
			u_q         <= '0;
			pow2_q      <= 1'b0;
			ones_q      <= '0;
			rb_q        <= '0;
			rval_q      <= '0;
			cur_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
			out_code_q  <= '0;
			out_cnt_q   <= '0;
			out_last_q  <= 1'b0;
			out_ovf_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				divisor_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_res.done) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					// offset for truncated binary: 2^b - m
					u_q <= golenc_pkg::VALUE_W'((17'd1 << div_res.nbits) - {1'b0, m_eff});
					pow2_q  <= ((m_eff & (m_eff - golenc_pkg::VALUE_W'(1))) == '0);
					state_q <= S_PLAN;
				end
				S_PLAN: begin
					ones_q <= QW'(div_res.quot);
					rb_q   <= plan_rbits;
					rval_q <= plan_rval;
					if (plan_ovf) begin
						state_q <= S_OVF;
					end else if (div_res.quot == '0) begin
						state_q <= S_STOP;
					end else begin
						state_q <= S_UNARY;
					end
				end
				S_UNARY, S_STOP, S_REM: begin
					if (!(flush && out_busy)) begin
						if (flush) begin
							out_valid_q <= 1'b1;
							out_code_q  <= cur_next;
							out_cnt_q   <= fill_next;
							out_last_q  <= bit_last;
							out_ovf_q   <= 1'b0;
							cur_q       <= '0;
							fill_q      <= '0;
						end else begin
							cur_q  <= cur_next;
							fill_q <= fill_next;
						end
						if (state_q == S_UNARY) begin
							ones_q <= ones_q - QW'(1);
							if (ones_q == QW'(1)) begin
								state_q <= S_STOP;
							end
						end else if (state_q == S_STOP) begin
							state_q <= (rb_q == '0) ? S_IDLE : S_REM;
						end else begin
							rb_q <= rb_q - golenc_pkg::NB_W'(1);
							if (bit_last) begin
								state_q <= S_IDLE;
							end
						end
					end
				end
				S_OVF: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
						out_code_q  <= '0;
						out_cnt_q   <= '0;
						out_last_q  <= 1'b1;
						out_ovf_q   <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign code_bits = out_code_q;
	assign bit_count = out_cnt_q;
	assign last      = out_last_q;
	assign overflow  = out_ovf_q;

	`GE_ASSERT(a_accept_div, accept |=> (state_q == S_DIV), "accepted word did not start divider")
	`GE_ASSERT(a_ovf_shape, (out_valid_q && out_ovf_q) |-> (out_cnt_q == '0 && out_last_q), "overflow word malformed")
	`GE_ASSERT(a_mid_full, (out_valid_q && !out_last_q) |-> (out_cnt_q == golenc_pkg::CNT_W'(CW)), "inner chunk not full")
	`GE_ASSERT(a_code_nonempty, (out_valid_q && !out_ovf_q) |-> (out_cnt_q != '0), "empty code chunk")

endmodule
